@@ hdl/lsu_pkg.sv @@
// Shared types and fixed widths of the level-set upwind update pipeline.
package lsu_pkg;

    // Width of every signed fixed-point value on the ports.
    localparam int VAL_W  = 32;
    // Width of the unsigned Q0.16 time step.
    localparam int DT_W   = 16;
    // Width of the integer square root of a sum of two squared axis terms.
    localparam int ROOT_W = 32;
    // Width of the radicand, the exact sum of squares.
    localparam int RAD_W  = 2 * VAL_W;
    // Width of the partial remainder carried between square-root steps.
    localparam int REM_W  = ROOT_W + 2;

    // One input beat.
    typedef struct packed {
        logic signed [VAL_W-1:0] level_value;
        logic signed [VAL_W-1:0] node_speed;
        logic signed [VAL_W-1:0] diff_x_back;
        logic signed [VAL_W-1:0] diff_x_fwd;
        logic signed [VAL_W-1:0] diff_y_back;
        logic signed [VAL_W-1:0] diff_y_fwd;
    } t_in_beat;

    // One output beat.
    typedef struct packed {
        logic signed [VAL_W-1:0] new_level_value;
        logic                    saturated_flag;
    } t_out_beat;

    // Values that ride alongside the gradient computation until the final update.
    typedef struct packed {
        logic signed [VAL_W-1:0] phi;
        logic [VAL_W-1:0]        fmag;
        logic                    neg;
    } t_side;

endpackage

@@ hdl/lsu_front.sv @@
// Front end: upwind axis terms, their squares and the sum of squares.
module lsu_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  lsu_pkg::t_in_beat          i_beat,
    output logic                       o_valid,
    output logic [lsu_pkg::RAD_W-1:0]  o_sum,
    output lsu_pkg::t_side             o_side
);
    import lsu_pkg::*;

    // Upwind term of one axis: the larger of sign(F)*back and -sign(F)*fwd, floored at zero.
    function automatic logic [VAL_W-1:0] axis_term(
        input logic              pos,
        input logic              neg,
        input logic [VAL_W-1:0]  back,
        input logic [VAL_W-1:0]  fwd
    );
        logic signed [VAL_W:0] b_x;
        logic signed [VAL_W:0] f_x;
        logic signed [VAL_W:0] a;
        logic signed [VAL_W:0] b;
        logic signed [VAL_W:0] m;
        b_x = {back[VAL_W-1], back};
        f_x = {fwd[VAL_W-1], fwd};
        a   = pos ? b_x : (neg ? -b_x : '0);
        b   = pos ? -f_x : (neg ? f_x : '0);
        m   = (a > b) ? a : b;
        return (m > $signed({(VAL_W+1){1'b0}})) ? m[VAL_W-1:0] : '0;
    endfunction

    logic              c_pos;
    logic              c_neg;
    logic [VAL_W-1:0]  c_tx;
    logic [VAL_W-1:0]  c_ty;
    t_side             c_side;

    logic              r_v1;
    logic [VAL_W-1:0]  r_tx;
    logic [VAL_W-1:0]  r_ty;
    t_side             r_side1;
    logic              r_v2;
    logic [RAD_W-1:0]  r_sqx;
    logic [RAD_W-1:0]  r_sqy;
    t_side             r_side2;
    logic              r_v3;
    logic [RAD_W-1:0]  r_sum;
    t_side             r_side3;

    always_comb begin
        c_neg       = i_beat.node_speed[VAL_W-1];
        c_pos       = !c_neg && (i_beat.node_speed != '0);
        c_tx        = axis_term(c_pos, c_neg, i_beat.diff_x_back, i_beat.diff_x_fwd);
        c_ty        = axis_term(c_pos, c_neg, i_beat.diff_y_back, i_beat.diff_y_fwd);
        c_side.phi  = i_beat.level_value;
        c_side.neg  = c_neg;
        // The most negative speed gives 2^31, which still fits unsigned.
        c_side.fmag = c_neg ? (~i_beat.node_speed + 1'b1) : i_beat.node_speed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tx    <= c_tx;
            r_ty    <= c_ty;
            r_side1 <= c_side;
            r_sqx   <= RAD_W'(r_tx) * RAD_W'(r_tx);
            r_sqy   <= RAD_W'(r_ty) * RAD_W'(r_ty);
            r_side2 <= r_side1;
            r_sum   <= r_sqx + r_sqy;
            r_side3 <= r_side2;
        end
    end

    assign o_valid = r_v3;
    assign o_sum   = r_sum;
    assign o_side  = r_side3;

endmodule

@@ hdl/lsu_sqrt.sv @@
// Pipelined integer square root, two result bits per register stage.
module lsu_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [lsu_pkg::RAD_W-1:0]   i_rad,
    input  lsu_pkg::t_side              i_side,
    output logic                        o_valid,
    output logic [lsu_pkg::ROOT_W-1:0]  o_root,
    output lsu_pkg::t_side              o_side
);
    import lsu_pkg::*;

    localparam int STEPS      = 2;
    localparam int NUM_STAGES = ROOT_W / STEPS;

    logic              r_v    [NUM_STAGES];
    logic [ROOT_W-1:0] r_root [NUM_STAGES];
    t_side             r_side [NUM_STAGES];
    // Remainder and unused radicand bits are only needed between stages.
    logic [RAD_W-1:0]  r_rad  [NUM_STAGES-1];
    logic [REM_W-1:0]  r_rem  [NUM_STAGES-1];

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        logic              v_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        t_side             side_in;
        logic [RAD_W-1:0]  rad_out;
        logic [REM_W-1:0]  rem_out;
        logic [ROOT_W-1:0] root_out;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rad_in  = r_rad[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            logic [REM_W+1:0] rem_sh;
            logic [REM_W+1:0] trial;
            rad_out  = rad_in;
            rem_out  = rem_in;
            root_out = root_in;
            for (int j = 0; j < STEPS; j++) begin
                rem_sh = {rem_out, rad_out[RAD_W-1 -: 2]};
                trial  = {2'b00, root_out, 2'b01};
                if (rem_sh >= trial) begin
                    rem_out  = REM_W'(rem_sh - trial);
                    root_out = {root_out[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_out  = rem_sh[REM_W-1:0];
                    root_out = {root_out[ROOT_W-2:0], 1'b0};
                end
                rad_out = rad_out << 2;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= root_out;
                r_side[k] <= side_in;
            end
        end

        if (k < NUM_STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[k] <= rad_out;
                    r_rem[k] <= rem_out;
                end
            end
        end
    end

    assign o_valid = r_v[NUM_STAGES-1];
    assign o_root  = r_root[NUM_STAGES-1];
    assign o_side  = r_side[NUM_STAGES-1];

endmodule

@@ hdl/lsu_scale.sv @@
// Back end: speed times gradient times time step, update of phi and saturation.
module lsu_scale #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [lsu_pkg::DT_W-1:0]    i_time_step,
    input  logic                        i_valid,
    input  logic [lsu_pkg::ROOT_W-1:0]  i_root,
    input  lsu_pkg::t_side              i_side,
    output logic                        o_valid,
    output lsu_pkg::t_out_beat          o_beat
);
    import lsu_pkg::*;

    localparam int P1_W   = VAL_W + ROOT_W;
    localparam int HALF_W = P1_W / 2;
    localparam int LO_W   = HALF_W + DT_W;
    localparam int PROD_W = P1_W + DT_W;
    localparam int SH     = FRAC_BITS + DT_W;
    // The decrement is always wider than a value, so the sum below cannot wrap.
    localparam int DEL_W  = PROD_W - SH;
    localparam int RES_W  = DEL_W + 2;
    localparam logic signed [RES_W-1:0] RES_MAX =
        {{(RES_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [RES_W-1:0] RES_MIN =
        {{(RES_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

    logic              r_v1;
    logic [P1_W-1:0]   r_p1;
    t_side             r_side1;
    logic              r_v2;
    logic [LO_W-1:0]   r_lo_dt;
    logic [HALF_W-1:0] r_hi;
    t_side             r_side2;
    logic              r_v3;
    logic [PROD_W-1:0] r_prod;
    t_side             r_side3;
    logic              r_v4;
    t_out_beat         r_beat;

    logic [LO_W-1:0]          c_upper;
    logic [DEL_W-1:0]         c_delta;
    logic signed [RES_W-1:0]  c_phi_x;
    logic signed [RES_W-1:0]  c_del_x;
    logic signed [RES_W-1:0]  c_res;
    t_out_beat                c_beat;

    always_comb begin
        c_upper = LO_W'(r_hi) * LO_W'(i_time_step) + LO_W'(r_lo_dt[LO_W-1:HALF_W]);
        c_delta = DEL_W'(r_prod >> SH);
        c_phi_x = {{(RES_W-VAL_W){r_side3.phi[VAL_W-1]}}, r_side3.phi};
        c_del_x = {2'b00, c_delta};
        // Positive speed moves the front outward, so phi falls; negative speed raises it.
        c_res   = r_side3.neg ? (c_phi_x + c_del_x) : (c_phi_x - c_del_x);
        priority if (c_res > RES_MAX) begin
            c_beat.new_level_value = RES_MAX[VAL_W-1:0];
            c_beat.saturated_flag  = 1'b1;
        end else if (c_res < RES_MIN) begin
            c_beat.new_level_value = RES_MIN[VAL_W-1:0];
            c_beat.saturated_flag  = 1'b1;
        end else begin
            c_beat.new_level_value = c_res[VAL_W-1:0];
            c_beat.saturated_flag  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1    <= P1_W'(i_side.fmag) * P1_W'(i_root);
            r_side1 <= i_side;
            r_lo_dt <= LO_W'(r_p1[HALF_W-1:0]) * LO_W'(i_time_step);
            r_hi    <= r_p1[P1_W-1:HALF_W];
            r_side2 <= r_side1;
            r_prod  <= {c_upper, r_lo_dt[HALF_W-1:0]};
            r_side3 <= r_side2;
            r_beat  <= c_beat;
        end
    end

    assign o_valid = r_v4;
    assign o_beat  = r_beat;

endmodule

@@ hdl/lsu_skid.sv @@
// Output register with a skid stage; holds the pipeline while both are full.
module lsu_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  lsu_pkg::t_out_beat  i_beat,
    output logic                o_en,
    output logic                o_valid,
    output lsu_pkg::t_out_beat  o_beat,
    input  logic                i_ready
);
    import lsu_pkg::*;

    logic      r_out_v;
    t_out_beat r_out;
    logic      r_skid_v;
    t_out_beat r_skid;
    logic      n_out_v;
    t_out_beat n_out;
    logic      n_skid_v;
    t_out_beat n_skid;
    logic      c_take;

    always_comb begin
        c_take   = i_valid && !r_skid_v;
        n_out_v  = r_out_v;
        n_out    = r_out;
        n_skid_v = r_skid_v;
        n_skid   = r_skid;
        if (!r_out_v || i_ready) begin
            if (r_skid_v) begin
                n_out_v  = 1'b1;
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end else begin
                n_out_v = c_take;
                n_out   = i_beat;
            end
        end else if (c_take) begin
            n_skid_v = 1'b1;
            n_skid   = i_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_en    = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_beat  = r_out;

endmodule

@@ hdl/level_set_upwind_update.sv @@
// Top level of the first-order Godunov upwind level-set update pipeline.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_ready    i_in_beat  (t_in_beat)
//   output    out        o_out_valid / i_out_ready  o_out_beat (t_out_beat)
//   config    in         i_cfg_we                   i_cfg_wdata (time step, Q0.16)
//
// One beat can enter on every clock cycle while the skid stage is empty. A beat passes 24
// registers: three front-end stages, sixteen square-root stages of two root bits each, four
// back-end stages and the output register. The first is loaded on the accepting edge.
// The synchronous active-low reset empties every stage and sets the time step to zero.
// A stall on the output first fills the skid stage; only then is the whole pipeline
// frozen and o_in_ready dropped, so no beat is lost or repeated.
module level_set_upwind_update #(
    // Fractional bits of the signed values; the range 8 to 24 is supported.
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  lsu_pkg::t_in_beat         i_in_beat,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output lsu_pkg::t_out_beat        o_out_beat,
    input  logic                      i_cfg_we,
    input  logic [lsu_pkg::DT_W-1:0]  i_cfg_wdata
);
    import lsu_pkg::*;

    // The user must rewrite the time step only while the pipeline is empty (the block
    // does not enforce this), so that every stage may read the live register.
    logic [DT_W-1:0] r_time_step;

    // Global advance: every stage moves forward together while the skid stage is empty.
    logic              pipe_en;

    logic              front_valid;
    logic [RAD_W-1:0]  front_sum;
    t_side             front_side;

    logic              sqrt_valid;
    logic [ROOT_W-1:0] sqrt_root;
    t_side             sqrt_side;

    logic              scale_valid;
    t_out_beat         scale_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= '0;
        end else if (i_cfg_we) begin
            r_time_step <= i_cfg_wdata;
        end
    end

    // Axis terms are picked by the sign of the speed, so that information always
    // comes from upwind. Zero speed gives zero terms and hence phi unchanged.
    lsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_in_valid && o_in_ready),
        .i_beat  (i_in_beat),
        .o_valid (front_valid),
        .o_sum   (front_sum),
        .o_side  (front_side)
    );

    // Floor of the square root of the sum of squares, which is the gradient
    // magnitude with the same number of fractional bits as the inputs.
    lsu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (front_valid),
        .i_rad   (front_sum),
        .i_side  (front_side),
        .o_valid (sqrt_valid),
        .o_root  (sqrt_root),
        .o_side  (sqrt_side)
    );

    // The exact product |F| * grad * dt is truncated towards zero and then
    // applied with the sign of F; the sum saturates to the signed 32-bit range.
    lsu_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (pipe_en),
        .i_time_step (r_time_step),
        .i_valid     (sqrt_valid),
        .i_root      (sqrt_root),
        .i_side      (sqrt_side),
        .o_valid     (scale_valid),
        .o_beat      (scale_beat)
    );

    lsu_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (scale_valid),
        .i_beat  (scale_beat),
        .o_en    (pipe_en),
        .o_valid (o_out_valid),
        .o_beat  (o_out_beat),
        .i_ready (i_out_ready)
    );

    // Ready comes straight from the skid register, so it never depends on i_in_valid.
    assign o_in_ready = pipe_en;

endmodule

@@ sim/level_set_checker.sv @@
`timescale 1ns / 1ps
// Checker that predicts and compares every output beat of the level-set upwind update.
module level_set_checker
    import lsu_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  t_in_beat            in_beat,
    input  logic                out_valid,
    input  logic                out_ready,
    input  t_out_beat           out_beat,
    input  logic                cfg_we,
    input  logic [DT_W-1:0]     cfg_wdata,
    output int                  mismatch_count,
    output int                  outstanding
);

    localparam longint PHI_MAX = (longint'(1) <<< 31) - 1;
    localparam longint PHI_MIN = -(longint'(1) <<< 31);

    logic [DT_W-1:0] step_dt;
    t_out_beat       pending_updates[$];
    int              mismatches;

    // Upwind one-sided term of one axis, clamped below at zero.
    function automatic longint upwind_term(input int dir, input longint back,
                                           input longint fwd);
        longint up_side;
        longint down_side;
        longint larger;
        up_side   = dir * back;
        down_side = -dir * fwd;
        larger    = (up_side > down_side) ? up_side : down_side;
        return (larger > 0) ? larger : 0;
    endfunction

    function automatic t_out_beat predict_update(input t_in_beat b,
                                                 input logic [DT_W-1:0] dt);
        t_out_beat   r;
        longint      phi;
        longint      speed;
        longint      tx;
        longint      ty;
        longint      updated;
        int          dir;
        logic [63:0] sum_sq;
        logic [63:0] root;
        logic [63:0] trial;
        logic [63:0] fmag;
        logic [95:0] scaled;
        logic [63:0] decr;
        phi   = b.level_value;
        speed = b.node_speed;
        r.saturated_flag = 1'b0;
        if (speed == 0) begin
            r.new_level_value = b.level_value;
            return r;
        end
        dir    = (speed > 0) ? 1 : -1;
        tx     = upwind_term(dir, b.diff_x_back, b.diff_x_fwd);
        ty     = upwind_term(dir, b.diff_y_back, b.diff_y_fwd);
        sum_sq = tx * tx + ty * ty;
        // Floor of the square root, settled one bit at a time from the top.
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= sum_sq) begin
                root = trial;
            end
        end
        fmag   = (speed < 0) ? -speed : speed;
        scaled = fmag;
        scaled = scaled * root;
        scaled = scaled * dt;
        decr   = scaled >> (FRAC_BITS + DT_W);
        updated = (dir > 0) ? phi - $signed(decr) : phi + $signed(decr);
        if (updated > PHI_MAX) begin
            updated = PHI_MAX;
            r.saturated_flag = 1'b1;
        end else if (updated < PHI_MIN) begin
            updated = PHI_MIN;
            r.saturated_flag = 1'b1;
        end
        r.new_level_value = updated[VAL_W-1:0];
        return r;
    endfunction

    initial begin
        mismatches = 0;
        step_dt    = '0;
    end

    always @(posedge clk) begin
        t_out_beat want;
        if (!rst_n) begin
            step_dt = '0;
            pending_updates.delete();
        end else begin
            if (out_valid && out_ready) begin
                if (pending_updates.size() == 0) begin
                    mismatches++;
                    $display("%0t: output beat with nothing outstanding: phi %0d flag %0b",
                             $time, out_beat.new_level_value, out_beat.saturated_flag);
                end else begin
                    want = pending_updates.pop_front();
                    if (out_beat.new_level_value !== want.new_level_value) begin
                        mismatches++;
                        $display("%0t: new_level_value expected %0d actual %0d",
                                 $time, want.new_level_value, out_beat.new_level_value);
                    end
                    if (out_beat.saturated_flag !== want.saturated_flag) begin
                        mismatches++;
                        $display("%0t: saturated_flag expected %0b actual %0b",
                                 $time, want.saturated_flag, out_beat.saturated_flag);
                    end
                end
            end
            if (in_valid && in_ready) begin
                pending_updates.push_back(predict_update(in_beat, step_dt));
            end
            if (cfg_we) begin
                step_dt = cfg_wdata;
            end
        end
        mismatch_count <= mismatches;
        outstanding    <= pending_updates.size();
    end

endmodule

@@ sim/tb_level_set_upwind_update.sv @@
`timescale 1ns / 1ps
// Testbench top: drives random and directed beats into the upwind update and gives the verdict.
module tb_level_set_upwind_update;
    import lsu_pkg::*;

    // The pipeline is 24 register stages deep; the tail wait after the last result allows a
    // margin on that.
    localparam int PIPE_DEPTH = 24;
    // Roughly 420 beats, each possibly waiting on the sender and on a stalling receiver, plus a
    // drain of the pipeline per phase, take far less time than the limit allows.
    localparam int CYCLE_LIMIT = 100000;
    localparam int PHASE_BEATS = 100;

    localparam logic signed [VAL_W-1:0] V_MAX = 32'sh7fff_ffff;
    localparam logic signed [VAL_W-1:0] V_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] ONE   = 32'sh0001_0000;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    t_in_beat        in_beat;
    logic            out_valid;
    logic            out_ready;
    t_out_beat       out_beat;
    logic            cfg_we;
    logic [DT_W-1:0] cfg_wdata;

    int mismatch_count;
    int outstanding;
    int cycle_count;
    // Percentages of cycles in which the sender idles and the receiver stalls.
    int send_idle_pct;
    int recv_stall_pct;

    level_set_upwind_update dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    level_set_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_beat        (in_beat),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_beat       (out_beat),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The watchdog: a hung handshake ends the run here rather than never.
    initial begin
        cycle_count = 0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // The receiver decides afresh on every edge whether it will take a beat, so stalls land on
    // every phase of the pipeline's work, the skid stage included.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_in_beat pack_node(input logic signed [VAL_W-1:0] phi,
                                           input logic signed [VAL_W-1:0] speed,
                                           input logic signed [VAL_W-1:0] x_back,
                                           input logic signed [VAL_W-1:0] x_fwd,
                                           input logic signed [VAL_W-1:0] y_back,
                                           input logic signed [VAL_W-1:0] y_fwd);
        t_in_beat b;
        b.level_value = phi;
        b.node_speed  = speed;
        b.diff_x_back = x_back;
        b.diff_x_fwd  = x_fwd;
        b.diff_y_back = y_back;
        b.diff_y_fwd  = y_fwd;
        return b;
    endfunction

    // Most values are either full 32-bit patterns or modest ones within sixteen units, so that
    // both saturating and ordinary updates turn up often; now and then an extreme is chosen.
    function automatic logic signed [VAL_W-1:0] random_value();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0:       v = V_MAX;
                    1:       v = V_MIN;
                    2:       v = '0;
                    3:       v = -1;
                    default: v = 1;
                endcase
            end
            1, 2, 3, 4: v = $urandom();
            default:    v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
        return v;
    endfunction

    function automatic t_in_beat random_node();
        logic signed [VAL_W-1:0] speed;
        speed = ($urandom_range(11) == 0) ? '0 : random_value();
        return pack_node(random_value(), speed, random_value(), random_value(),
                         random_value(), random_value());
    endfunction

    // Offers one beat. Idle cycles come first, with valid low; once valid is raised it stays
    // high with the payload held until the beat is taken. Back-to-back beats keep valid high.
    task automatic send_beat(input t_in_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
    endtask

    // Stops sending and waits for every outstanding result. The count from the checker is
    // registered, so it is only read after the clock has advanced.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (outstanding != 0);
    endtask

    task automatic write_time_step(input logic [DT_W-1:0] dt);
        cfg_we    <= 1'b1;
        cfg_wdata <= dt;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One random phase: the pipeline is emptied, the time step rewritten and the idling
    // pattern set, then a stream of random nodes goes in. Halfway through, the sender holds
    // off until every result so far has come back.
    task automatic run_phase(input logic [DT_W-1:0] dt, input int idle_pct,
                             input int stall_pct);
        drain_pipeline();
        write_time_step(dt);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < PHASE_BEATS; n++) begin
            if (n == PHASE_BEATS / 2) begin
                drain_pipeline();
            end
            send_beat(random_node());
        end
    endtask

    initial begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        in_beat        <= '0;
        out_ready      <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The time step is zero out of reset, so even the steepest node must keep its phi.
        send_beat(pack_node(5 * ONE, V_MAX, V_MAX, V_MIN, V_MAX, V_MIN));
        send_beat(pack_node(V_MIN, V_MIN, V_MIN, V_MAX, V_MIN, V_MAX));
        send_beat(pack_node(-ONE, ONE, ONE, -ONE, ONE, -ONE));

        drain_pipeline();
        write_time_step(16'hffff);
        // Zero speed leaves phi alone whatever the differences are.
        send_beat(pack_node(V_MAX, '0, V_MIN, V_MAX, V_MIN, V_MAX));
        send_beat(pack_node(V_MIN, '0, V_MAX, V_MIN, V_MAX, V_MIN));
        // Flat neighbourhood: no gradient, no change.
        send_beat(pack_node(ONE, ONE, '0, '0, '0, '0));
        // Positive speed, both one-sided differences upwind in x only.
        send_beat(pack_node(3 * ONE, ONE, ONE, -ONE, '0, '0));
        // Positive speed with both axis terms negative, so both clamp to zero.
        send_beat(pack_node(ONE, ONE, -ONE, ONE, -2 * ONE, 3 * ONE));
        // Negative speed, upwind on both sides, gradient in y only.
        send_beat(pack_node('0, -ONE, '0, '0, -ONE, ONE));
        // Negative speed with both axis terms clamped.
        send_beat(pack_node(ONE, -2 * ONE, ONE, -ONE, 4 * ONE, -ONE));
        // Steepest gradient pushes phi below the bottom of the range.
        send_beat(pack_node(V_MIN, V_MAX, V_MAX, V_MIN, V_MAX, V_MIN));
        // The mirror case saturates at the top of the range.
        send_beat(pack_node(V_MAX, V_MIN, V_MIN, V_MAX, V_MIN, V_MAX));
        // Every field at the most negative value, and every field at the most positive.
        send_beat(pack_node(V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN));
        send_beat(pack_node(V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX));
        // The smallest speeds of either sign against large differences.
        send_beat(pack_node(ONE, 1, V_MAX, V_MIN, V_MAX, V_MIN));
        send_beat(pack_node(-ONE, -1, V_MIN, V_MAX, V_MIN, V_MAX));
        // Largest speed magnitude with a unit gradient, so the decrement is large but in range.
        send_beat(pack_node('0, V_MIN, -ONE, ONE, '0, '0));
        // Every bit set in every field.
        send_beat(pack_node(-1, -1, -1, -1, -1, -1));
        send_beat(pack_node(ONE, ONE, 3 * ONE, '0, 4 * ONE, '0));

        run_phase(DT_W'($urandom_range(1, 16'hfffe)), 0, 0);
        run_phase(16'h0001, 63, 0);
        run_phase(16'hffff, 0, 63);
        run_phase(16'h8000, 11, 11);

        drain_pipeline();
        repeat (PIPE_DEPTH + 16) @(posedge clk);
        if (outstanding != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, outstanding);
        end
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/lsu_pkg.sv
hdl/lsu_front.sv
hdl/lsu_sqrt.sv
hdl/lsu_scale.sv
hdl/lsu_skid.sv
hdl/level_set_upwind_update.sv
sim/level_set_checker.sv
sim/tb_level_set_upwind_update.sv
